### design/cmeq_pkg.sv
// shared constants for the cube-map to equirectangular remap pipeline
// fixed-point formats, size limits and angle widths
// no dependencies
package cmeq_pkg;

  // internal fixed point: signed, 24 fraction bits
  localparam int FB   = 24;
  localparam int ONE  = 1 << FB;
  localparam int HALF = 1 << (FB - 1);

  // size limits and output format
  localparam int MAX_FACE        = 2048;
  localparam int MAX_EQUI_HEIGHT = 4096;
  localparam int OUT_FRAC_BITS   = 8;
  localparam int RND_SH          = FB - OUT_FRAC_BITS;

  // widths of the cube point and of an angle in turns
  localparam int QW = 26;
  localparam int ZW = 26;

  // atan2 unit: one pre-rotation stage plus ten stages of two micro-rotations
  localparam int CORDIC_STG = 10;
  localparam int CORDIC_LAT = CORDIC_STG + 1;

endpackage

### design/cmeq_cordic.sv
// pipelined cordic atan2, result in turns with 24 fraction bits
// half-turn pre-rotation for a negative x, atan2(0,0) gives zero
// depends on cmeq_pkg
module cmeq_cordic import cmeq_pkg::*; (
  input  logic                 clk_i,
  input  logic signed [QW-1:0] y_i,
  input  logic signed [QW-1:0] x_i,
  output logic signed [ZW-1:0] z_o
);

  localparam int CW = 28;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } rot_t;

  // atan(2^-i) in turns
  function automatic logic signed [ZW-1:0] turn(input int i);
    logic signed [ZW-1:0] t;
    case (i)
      0:  t = ZW'(2097152);
      1:  t = ZW'(1238021);
      2:  t = ZW'(654136);
      3:  t = ZW'(332050);
      4:  t = ZW'(166669);
      5:  t = ZW'(83416);
      6:  t = ZW'(41718);
      7:  t = ZW'(20860);
      8:  t = ZW'(10430);
      9:  t = ZW'(5215);
      10: t = ZW'(2608);
      11: t = ZW'(1304);
      12: t = ZW'(652);
      13: t = ZW'(326);
      14: t = ZW'(163);
      15: t = ZW'(81);
      16: t = ZW'(41);
      17: t = ZW'(20);
      18: t = ZW'(10);
      19: t = ZW'(5);
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic rot_t rot(input rot_t s, input int i);
    rot_t o;
    logic signed [CW-1:0] sx, sy, xs, ys;
    logic signed [ZW-1:0] sz;
    sx = s.x;
    sy = s.y;
    sz = s.z;
    xs = sx >>> i;
    ys = sy >>> i;
    if (sy > 0) begin
      o.x = sx + ys;
      o.y = sy - xs;
      o.z = sz + turn(i);
    end else begin
      o.x = sx - ys;
      o.y = sy + xs;
      o.z = sz - turn(i);
    end
    return o;
  endfunction

  rot_t pre_d;
  logic zero_d;
  rot_t st_q [CORDIC_STG+1];
  logic zf_q [CORDIC_STG+1];

  // half-turn pre-rotation
  always_comb begin
    zero_d = (x_i == '0) && (y_i == '0);
    if (x_i < 0) begin
      pre_d.x = -CW'(x_i);
      pre_d.y = -CW'(y_i);
      pre_d.z = (y_i >= 0) ? ZW'(HALF) : -ZW'(HALF);
    end else begin
      pre_d.x = CW'(x_i);
      pre_d.y = CW'(y_i);
      pre_d.z = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= pre_d;
    zf_q[0] <= zero_d;
    for (int k = 1; k <= CORDIC_STG; k++) begin
      st_q[k] <= rot(rot(st_q[k-1], 2*k-2), 2*k-1);
      zf_q[k] <= zf_q[k-1];
    end
  end

  assign z_o = zf_q[CORDIC_STG] ? '0 : st_q[CORDIC_STG].z;

endmodule

### design/cubemap_layout_to_equirect_coords.sv
// cube-map pixel to equirectangular source coordinate, top level
// divider, face select, isqrt and two cordic atan2 units in one pipeline
// depends on cmeq_pkg and cmeq_cordic

// One item (column, row) enters on every clock at which start_i is high;
// busy_o is never raised. Each item leaves in order, marked by a one-cycle
// valid_o with src_x_o and src_y_o. The pipeline holds 1 input stage, 8
// stages of the two normalizing long divisions (3 quotient bits each), face
// select, cube point, squares, sum, 12 stages of integer square root (2 result
// bits each), the 11-stage cordic atan2 and two stages of clamp and scaling.
// The receiver cannot stall, so nothing holds the pipeline. Registers sit on
// an APB port (layout at 0x0, face_size at 0x4, equirect_height at 0x8);
// change them only while no item is in flight. Outputs are unsigned with 8
// fraction bits.
module cubemap_layout_to_equirect_coords import cmeq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [13:0] column_i,
  input  logic [11:0] row_i,
  output logic        valid_o,
  output logic [21:0] src_x_o,
  output logic [20:0] src_y_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // register map
  localparam logic [1:0] REG_LAYOUT = 2'd0;
  localparam logic [1:0] REG_FACE   = 2'd1;
  localparam logic [1:0] REG_EQUI   = 2'd2;

  // layout codes, the unused code runs as the strip
  localparam logic [1:0] LAY_GRID   = 2'd1;
  localparam logic [1:0] LAY_PACKED = 2'd2;

  // cube faces
  localparam logic [2:0] FACE_PX = 3'd0;
  localparam logic [2:0] FACE_NX = 3'd1;
  localparam logic [2:0] FACE_PY = 3'd2;
  localparam logic [2:0] FACE_NY = 3'd3;
  localparam logic [2:0] FACE_PZ = 3'd4;
  localparam logic [2:0] FACE_NZ = 3'd5;

  // pipeline positions
  localparam int DIV_STG = 8;
  localparam int SQ_STG  = 12;
  localparam int P_FACE  = DIV_STG + 1;
  localparam int P_SUM   = P_FACE + 3;
  localparam int P_ROOT  = P_SUM + SQ_STG;
  localparam int P_ANG   = P_ROOT + CORDIC_LAT;
  localparam int P_OUT   = P_ANG + 2;
  localparam int NSTG    = P_OUT + 1;
  localparam int VEC_N   = SQ_STG + 3;

  // packed-layout thresholds, rounded to nearest
  localparam logic signed [27:0] T13 = 28'sd5592405;
  localparam logic signed [27:0] T23 = 28'sd11184811;
  localparam logic signed [27:0] T16 = 28'sd2796203;
  localparam logic signed [27:0] T01 = 28'sd1677722;
  localparam logic signed [27:0] T02 = 28'sd3355443;
  localparam logic signed [27:0] T04 = 28'sd6710886;
  localparam logic signed [27:0] T06 = 28'sd10066330;
  localparam logic signed [27:0] T08 = 28'sd13421773;
  localparam logic signed [27:0] H28 = 28'(HALF);
  localparam logic signed [27:0] ONE28 = 28'(ONE);
  localparam logic signed [QW-1:0] HQ = QW'(HALF);

  typedef struct packed {
    logic signed [QW-1:0] qx;
    logic signed [QW-1:0] qy;
    logic signed [QW-1:0] qz;
  } vec_t;

  // three quotient bits of r * 2^24 / d
  function automatic logic [39:0] div_step3(input logic [15:0] r, input logic [23:0] q,
                                            input logic [15:0] d);
    logic [16:0] t;
    logic [15:0] rr;
    logic [23:0] qq;
    rr = r;
    qq = q;
    for (int n = 0; n < 3; n++) begin
      t = {rr, 1'b0};
      if (t >= {1'b0, d}) begin
        rr = 16'(t - {1'b0, d});
        qq = {qq[22:0], 1'b1};
      end else begin
        rr = t[15:0];
        qq = {qq[22:0], 1'b0};
      end
    end
    return {rr, qq};
  endfunction

  // two result bits of the integer square root, j counts result bits from the top
  function automatic logic [95:0] sqrt_step2(input logic [47:0] rem, input logic [47:0] res,
                                             input int j);
    logic [47:0] rm, rs, bw;
    rm = rem;
    rs = res;
    for (int n = 0; n < 2; n++) begin
      bw = 48'd1 << (46 - 2 * (j + n));
      if (rm >= rs + bw) begin
        rm = rm - (rs + bw);
        rs = (rs >> 1) + bw;
      end else begin
        rs = rs >> 1;
      end
    end
    return {rm, rs};
  endfunction

  // configuration registers
  logic [1:0]  layout_q;
  logic [11:0] face_size_q;
  logic [12:0] equi_h_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign busy_o = 1'b0;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      layout_q    <= 2'd0;
      face_size_q <= 12'd512;
      equi_h_q    <= 13'd1024;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LAYOUT: layout_q    <= pwdata[1:0];
        REG_FACE:   face_size_q <= pwdata[11:0];
        REG_EQUI:   equi_h_q    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LAYOUT: prdata = {30'd0, layout_q};
      REG_FACE:   prdata = {20'd0, face_size_q};
      REG_EQUI:   prdata = {19'd0, equi_h_q};
      default:    prdata = '0;
    endcase
  end

  // saturated sizes and image extent; only the user keeps them static while items are in flight
  logic [11:0] f_sat;
  logic [12:0] e_sat;
  logic [12:0] f3;
  logic [14:0] f5;
  logic [13:0] img_w;
  logic [12:0] img_h;
  logic [15:0] div_x;
  logic [15:0] div_y;

  always_comb begin
    if (face_size_q == '0) begin
      f_sat = 12'd1;
    end else if (face_size_q > 12'(MAX_FACE)) begin
      f_sat = 12'(MAX_FACE);
    end else begin
      f_sat = face_size_q;
    end
    e_sat = (equi_h_q > 13'(MAX_EQUI_HEIGHT)) ? 13'(MAX_EQUI_HEIGHT) : equi_h_q;
    f3 = {1'b0, f_sat} + {f_sat, 1'b0};
    f5 = {3'b0, f_sat} + {1'b0, f_sat, 2'b0};
    case (layout_q)
      LAY_GRID: begin
        img_w = {1'b0, f3};
        img_h = {f_sat, 1'b0};
      end
      LAY_PACKED: begin
        img_w = f5[14:1];
        img_h = {1'b0, f3[12:1]};
      end
      default: begin
        img_w = {f3, 1'b0};
        img_h = {1'b0, f_sat};
      end
    endcase
    div_x = {1'b0, img_w, 1'b0};
    div_y = {2'b0, img_h, 1'b0};
  end

  // input stage: clip to the image
  logic [13:0] w_m1;
  logic [12:0] h_m1;
  logic [13:0] col_sat;
  logic [11:0] row_sat;

  always_comb begin
    w_m1    = img_w - 14'd1;
    h_m1    = img_h - 13'd1;
    col_sat = (column_i > w_m1) ? w_m1 : column_i;
    row_sat = ({1'b0, row_i} > h_m1) ? h_m1[11:0] : row_i;
  end

  // valid bits travel down the whole pipeline
  logic vld_q [NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NSTG; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      vld_q[0] <= start_i & ~busy_o;
      for (int k = 1; k < NSTG; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // normalizing dividers: remainder and quotient per stage
  logic [15:0] xr_q [DIV_STG+1];
  logic [23:0] xq_q [DIV_STG+1];
  logic [15:0] yr_q [DIV_STG+1];
  logic [23:0] yq_q [DIV_STG+1];

  always_ff @(posedge clk_i) begin
    xr_q[0] <= {1'b0, col_sat, 1'b1};
    xq_q[0] <= '0;
    yr_q[0] <= {3'b0, row_sat, 1'b1};
    yq_q[0] <= '0;
    for (int k = 1; k <= DIV_STG; k++) begin
      {xr_q[k], xq_q[k]} <= div_step3(xr_q[k-1], xq_q[k-1], div_x);
      {yr_q[k], yq_q[k]} <= div_step3(yr_q[k-1], yq_q[k-1], div_y);
    end
  end

  // face select and in-face coordinates
  logic [23:0] u_n;
  logic [23:0] v_n;
  logic [26:0] m6;
  logic [25:0] m3;
  logic [24:0] m2;
  logic signed [27:0] xs, ys;
  logic [2:0] face_d, face_q;
  logic signed [27:0] fx_d, fy_d, fx_q, fy_q;

  always_comb begin
    u_n = xq_q[DIV_STG];
    v_n = 24'd0 - yq_q[DIV_STG];   // 1 - v, never reaches one
    m6  = 27'(u_n) * 27'd6;
    m3  = 26'(u_n) * 26'd3;
    m2  = {v_n, 1'b0};
    xs  = signed'({4'b0, u_n});
    ys  = signed'({4'b0, v_n});
    case (layout_q)
      LAY_GRID: begin
        face_d = {1'b0, m3[25:24]} + (m2[24] ? 3'd0 : 3'd3);
        fx_d   = signed'({4'b0, m3[23:0]});
        fy_d   = signed'({4'b0, m2[23:0]});
      end
      LAY_PACKED: begin
        if (ys < T13 && xs < T08) begin
          // bottom band: halves of the NX, PX, PY and NY faces, then the squashed other half of NY
          if (xs < T01) begin
            face_d = FACE_NX;
            fx_d   = xs * 28'sd5;
            fy_d   = ys * 28'sd3;
          end else if (xs < T02) begin
            face_d = FACE_PX;
            fx_d   = (xs - T01) * 28'sd5 + H28;
            fy_d   = ys * 28'sd3;
          end else if (xs < T04) begin
            if (ys >= T16) begin
              face_d = FACE_PY;
              fx_d   = (xs - T02) * 28'sd5;
              fy_d   = (ys - T16) * 28'sd3 + H28;
            end else begin
              face_d = FACE_NY;
              fx_d   = (xs - T02) * 28'sd5;
              fy_d   = ys * 28'sd3;
            end
          end else begin
            face_d = FACE_NY;
            fx_d   = ((xs - T04) * 28'sd5) >>> 1;
            fy_d   = ((ys * 28'sd3) >>> 1) + H28;
          end
        end else if (ys >= T23 && xs >= T06) begin
          face_d = FACE_PY;
          fx_d   = ((xs - T06) * 28'sd5) >>> 1;
          fy_d   = ((ys - T23) * 28'sd3) >>> 1;
        end else if (xs < T04) begin
          face_d = FACE_PZ;
          fx_d   = (xs * 28'sd5) >>> 1;
          fy_d   = ((ys - T13) * 28'sd3) >>> 1;
        end else if (xs < T06) begin
          face_d = FACE_NX;
          fx_d   = (((xs - T04) * 28'sd5) >>> 1) + H28;
          fy_d   = ((ys - T13) * 28'sd3) >>> 1;
        end else if (xs < T08) begin
          face_d = FACE_NZ;
          fx_d   = (xs - T06) * 28'sd5;
          fy_d   = (ys - T13) * 28'sd3;
        end else begin
          face_d = FACE_PX;
          fx_d   = ((xs - T08) * 28'sd5) >>> 1;
          fy_d   = (ys * 28'sd3) >>> 1;
        end
      end
      default: begin
        face_d = m6[26:24];
        fx_d   = signed'({4'b0, m6[23:0]});
        fy_d   = ys;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    face_q <= face_d;
    fx_q   <= fx_d;
    fy_q   <= fy_d;
  end

  // point on the unit cube
  vec_t vec_d;

  always_comb begin
    case (face_q)
      FACE_PX: begin
        vec_d.qx = HQ;
        vec_d.qy = QW'(fy_q - H28);
        vec_d.qz = QW'(H28 - fx_q);
      end
      FACE_NX: begin
        vec_d.qx = -HQ;
        vec_d.qy = QW'(fy_q - H28);
        vec_d.qz = QW'(fx_q - H28);
      end
      FACE_PY: begin
        vec_d.qx = QW'(fx_q - H28);
        vec_d.qy = HQ;
        vec_d.qz = QW'(H28 - fy_q);
      end
      FACE_NY: begin
        vec_d.qx = QW'(fx_q - H28);
        vec_d.qy = -HQ;
        vec_d.qz = QW'(fy_q - H28);
      end
      FACE_PZ: begin
        vec_d.qx = QW'(fx_q - H28);
        vec_d.qy = QW'(fy_q - H28);
        vec_d.qz = HQ;
      end
      default: begin
        vec_d.qx = QW'(H28 - fx_q);
        vec_d.qy = QW'(fy_q - H28);
        vec_d.qz = -HQ;
      end
    endcase
  end

  // cube point rides along with the squares and the square root
  vec_t vec_q [VEC_N];
  logic signed [2*QW-1:0] px2, pz2;
  logic [46:0] sq_x_q, sq_z_q;
  logic [47:0] rem_q [SQ_STG+1];
  logic [47:0] res_q [SQ_STG+1];

  assign px2 = vec_q[0].qx * vec_q[0].qx;
  assign pz2 = vec_q[0].qz * vec_q[0].qz;

  always_ff @(posedge clk_i) begin
    vec_q[0] <= vec_d;
    for (int k = 1; k < VEC_N; k++) begin
      vec_q[k] <= vec_q[k-1];
    end
    sq_x_q   <= px2[46:0];
    sq_z_q   <= pz2[46:0];
    rem_q[0] <= {1'b0, sq_x_q} + {1'b0, sq_z_q};
    res_q[0] <= '0;
    for (int k = 1; k <= SQ_STG; k++) begin
      {rem_q[k], res_q[k]} <= sqrt_step2(rem_q[k-1], res_q[k-1], 2 * (k - 1));
    end
  end

  // longitude and latitude
  logic signed [QW-1:0] lon_y, lon_x, lat_y, lat_x;
  logic signed [ZW-1:0] ang_a, ang_b;

  assign lon_y = -vec_q[VEC_N-1].qx;
  assign lon_x = vec_q[VEC_N-1].qz;
  assign lat_y = -vec_q[VEC_N-1].qy;
  assign lat_x = signed'({2'b0, res_q[SQ_STG][23:0]});

  cmeq_cordic u_lon (
    .clk_i (clk_i),
    .y_i   (lon_y),
    .x_i   (lon_x),
    .z_o   (ang_a)
  );

  cmeq_cordic u_lat (
    .clk_i (clk_i),
    .y_i   (lat_y),
    .x_i   (lat_x),
    .z_o   (ang_b)
  );

  // clamp to [0,1] then scale to the source size, rounding half up
  logic signed [27:0] frx_d, fry_d;
  logic [24:0] frx_q, fry_q;
  logic [38:0] prod_x, prod_y;
  logic [21:0] src_x_q;
  logic [20:0] src_y_q;

  always_comb begin
    frx_d = H28 - 28'(ang_a);
    fry_d = H28 + (28'(ang_b) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (frx_d < 0)          frx_q <= '0;
    else if (frx_d > ONE28) frx_q <= 25'(ONE);
    else                    frx_q <= frx_d[24:0];
    if (fry_d < 0)          fry_q <= '0;
    else if (fry_d > ONE28) fry_q <= 25'(ONE);
    else                    fry_q <= fry_d[24:0];
  end

  assign prod_x = 39'(frx_q) * 39'({e_sat, 1'b0}) + 39'(1 << (RND_SH - 1));
  assign prod_y = 39'(fry_q) * 39'(e_sat) + 39'(1 << (RND_SH - 1));

  always_ff @(posedge clk_i) begin
    src_x_q <= prod_x[RND_SH+21:RND_SH];
    src_y_q <= prod_y[RND_SH+20:RND_SH];
  end

  assign valid_o = vld_q[P_OUT];
  assign src_x_o = src_x_q;
  assign src_y_o = src_y_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start_i, NSTG))
    else $error("result strobe without a matching item");

  a_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[P_FACE] |-> face_q <= FACE_NZ)
    else $error("face code out of range");

  a_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[P_ROOT] |-> res_q[SQ_STG][47:24] == '0)
    else $error("square root wider than the cube radius");

  a_src_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> src_x_o <= 22'd2097152)
    else $error("src_x beyond full width");

  a_src_y: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> src_y_o <= 21'd1048576)
    else $error("src_y beyond full height");
`endif

endmodule

### bench/testbench.sv
// testbench for the cube-map to equirectangular remap pipeline
// self-checking: a scoreboard class predicts src_x / src_y for every accepted item
// depends on cmeq_pkg and cubemap_layout_to_equirect_coords
`timescale 1ns / 1ps

module testbench import cmeq_pkg::*;;

  // register indexes; byte address is four times the index
  typedef enum int {REG_LAYOUT = 0, REG_FACE_SIZE = 1, REG_EQUI_HEIGHT = 2} reg_idx_e;

  // layout codes
  localparam int LAYOUT_STRIP  = 0;
  localparam int LAYOUT_GRID   = 1;
  localparam int LAYOUT_PACKED = 2;
  localparam int LAYOUT_SPARE  = 3;

  // q.24 constants of the prediction
  localparam longint Q_ONE  = 64'sd1 << 24;
  localparam longint Q_HALF = 64'sd1 << 23;
  localparam longint T13 = 5592405;
  localparam longint T23 = 11184811;
  localparam longint T16 = 2796203;
  localparam longint T01 = 1677722;
  localparam longint T02 = 3355443;
  localparam longint T04 = 6710886;
  localparam longint T06 = 10066330;
  localparam longint T08 = 13421773;
  localparam int ROT_STEPS = 20;

  class remap_scoreboard;
    int unsigned layout_cfg = 0;
    int unsigned face_cfg   = 512;
    int unsigned equi_cfg   = 1024;
    bit [21:0] exp_x_q[$];
    bit [20:0] exp_y_q[$];
    int errors  = 0;
    int results = 0;
    int items   = 0;
    longint rot_tab[ROT_STEPS] = '{2097152, 1238021, 654136, 332050, 166669, 83416,
                                   41718, 20860, 10430, 5215, 2608, 1304, 652, 326,
                                   163, 81, 41, 20, 10, 5};

    task report(string what);
      errors++;
      $display("mismatch at %0t: %s", $time, what);
    endtask

    // atan2 in turns, cordic with half-turn pre-rotation
    function longint atan_turns(longint yy, longint xx);
      longint z, xs, ys;
      z = 0;
      if (xx == 0 && yy == 0) return 0;
      if (xx < 0) begin
        z = (yy >= 0) ? Q_HALF : -Q_HALF;
        xx = -xx;
        yy = -yy;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
        xs = xx >>> i;
        ys = yy >>> i;
        if (yy > 0) begin
          xx += ys; yy -= xs; z += rot_tab[i];
        end else begin
          xx -= ys; yy += xs; z -= rot_tab[i];
        end
      end
      return z;
    endfunction

    function longint root64(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else res >>= 1;
        b >>= 2;
      end
      return longint'(res);
    endfunction

    // clamp to [0,1] and round half up to the output fraction bits
    function bit [63:0] scale_frac(longint frac, longint size);
      bit [63:0] p;
      if (frac < 0) frac = 0;
      if (frac > Q_ONE) frac = Q_ONE;
      p = frac * size;
      return (p + 64'd32768) >> 16;
    endfunction

    // predict the source coordinate of one accepted pixel
    function void note(bit [13:0] col_in, bit [11:0] row_in);
      longint f, e, w, h, col, row, x, y, qx, qy, qz, a, b, r, vf, hf, fi;
      int face;
      bit [63:0] sx, sy;
      face = 0;
      f = face_cfg;
      e = equi_cfg;
      if (f < 1) f = 1;
      if (f > MAX_FACE) f = MAX_FACE;
      if (e > MAX_EQUI_HEIGHT) e = MAX_EQUI_HEIGHT;
      if (layout_cfg == LAYOUT_GRID) begin
        w = 3 * f; h = 2 * f;
      end else if (layout_cfg == LAYOUT_PACKED) begin
        w = (5 * f) >> 1; h = (3 * f) >> 1;
      end else begin
        w = 6 * f; h = f;
      end
      col = col_in;
      row = row_in;
      if (col > w - 1) col = w - 1;
      if (row > h - 1) row = h - 1;
      x = ((2 * col + 1) << 24) / (2 * w);
      y = Q_ONE - ((2 * row + 1) << 24) / (2 * h);

      if (layout_cfg == LAYOUT_GRID) begin
        vf = (y * 2) >>> 24;
        hf = (x * 3) >>> 24;
        x = x * 3 - hf * Q_ONE;
        y = y * 2 - vf * Q_ONE;
        face = int'(hf + (1 - vf) * 3);
      end else if (layout_cfg == LAYOUT_PACKED) begin
        if (y < T13 && x < T08) begin
          if (x < T01) begin
            face = 1; x = x * 5; y = y * 3;
          end else if (x < T02) begin
            face = 0; x = (x - T01) * 5 + Q_HALF; y = y * 3;
          end else if (x < T04) begin
            if (y >= T16) begin
              face = 2; x = (x - T02) * 5; y = (y - T16) * 3 + Q_HALF;
            end else begin
              face = 3; x = (x - T02) * 5; y = y * 3;
            end
          end else begin
            face = 3; x = ((x - T04) * 5) >>> 1; y = ((y * 3) >>> 1) + Q_HALF;
          end
        end else if (y >= T23 && x >= T06) begin
          face = 2; x = ((x - T06) * 5) >>> 1; y = ((y - T23) * 3) >>> 1;
        end else if (x < T04) begin
          face = 4; x = (x * 5) >>> 1; y = ((y - T13) * 3) >>> 1;
        end else if (x < T06) begin
          face = 1; x = (((x - T04) * 5) >>> 1) + Q_HALF; y = ((y - T13) * 3) >>> 1;
        end else if (x < T08) begin
          face = 5; x = (x - T06) * 5; y = (y - T13) * 3;
        end else begin
          face = 0; x = ((x - T08) * 5) >>> 1; y = (y * 3) >>> 1;
        end
      end else begin
        fi = (x * 6) >>> 24;
        x = x * 6 - fi * Q_ONE;
        face = int'(fi);
      end

      // point on the unit cube
      case (face)
        0: begin qx = Q_HALF;     qy = y - Q_HALF; qz = Q_HALF - x; end
        1: begin qx = -Q_HALF;    qy = y - Q_HALF; qz = x - Q_HALF; end
        2: begin qx = x - Q_HALF; qy = Q_HALF;     qz = Q_HALF - y; end
        3: begin qx = x - Q_HALF; qy = -Q_HALF;    qz = y - Q_HALF; end
        4: begin qx = x - Q_HALF; qy = y - Q_HALF; qz = Q_HALF;     end
        default: begin qx = Q_HALF - x; qy = y - Q_HALF; qz = -Q_HALF; end
      endcase

      a = atan_turns(-qx, qz);
      r = root64(64'(qx * qx) + 64'(qz * qz));
      b = atan_turns(-qy, r);
      sx = scale_frac(Q_HALF - a, 2 * e);
      sy = scale_frac(Q_HALF + 2 * b, e);
      exp_x_q.push_back(sx[21:0]);
      exp_y_q.push_back(sy[20:0]);
      items++;
    endfunction

    task check(bit [21:0] got_x, bit [20:0] got_y);
      bit [21:0] ex;
      bit [20:0] ey;
      results++;
      if (exp_x_q.size() == 0) begin
        report($sformatf("result x=%0d y=%0d with nothing expected", got_x, got_y));
        return;
      end
      ex = exp_x_q.pop_front();
      ey = exp_y_q.pop_front();
      if (got_x !== ex) report($sformatf("src_x got %0d want %0d", got_x, ex));
      if (got_y !== ey) report($sformatf("src_y got %0d want %0d", got_y, ey));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [13:0] column_i = '0;
  logic [11:0] row_i = '0;
  logic        valid_o;
  logic [21:0] src_x_o;
  logic [20:0] src_y_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  remap_scoreboard remap_sb = new();
  bit quiet_sender = 1'b0;    // no idle cycles while set
  int phase_count = 0;

  always #5 clk_i = ~clk_i;

  cubemap_layout_to_equirect_coords u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .column_i(column_i),
    .row_i   (row_i),
    .valid_o (valid_o),
    .src_x_o (src_x_o),
    .src_y_o (src_y_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // every strobed result is taken at the edge that ends its cycle
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) remap_sb.check(src_x_o, src_y_o);
  end

  // apb write: setup cycle, then access cycle
  task reg_write(reg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 4'(4 * idx);
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_LAYOUT:      remap_sb.layout_cfg = value & 32'h3;
      REG_FACE_SIZE:   remap_sb.face_cfg = value & 32'hFFF;
      default:         remap_sb.equi_cfg = value & 32'h1FFF;
    endcase
  endtask

  // hand one pixel to the block, with random idle cycles ahead of it unless quiet_sender is set
  task send_pixel(bit [13:0] col, bit [11:0] row);
    bit taken;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      if (!quiet_sender && $urandom_range(99) < 12) begin
        start_i = 1'b0;
      end else begin
        start_i = 1'b1;
        column_i = col;
        row_i = row;
        @(posedge clk_i);
        if (!busy_o) begin
          taken = 1'b1;
          remap_sb.note(col, row);
        end
      end
    end
  endtask

  task drain;
    @(negedge clk_i);
    start_i = 1'b0;
    while (remap_sb.exp_x_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // new setting, then a burst of random pixels, mostly inside the image
  task run_phase(int unsigned lay, int unsigned fsize, int unsigned eh, int n);
    int unsigned f, w, h;
    drain();
    reg_write(REG_LAYOUT, lay);
    reg_write(REG_FACE_SIZE, fsize);
    reg_write(REG_EQUI_HEIGHT, eh);
    phase_count++;
    f = (fsize & 32'hFFF) == 0 ? 1 : ((fsize & 32'hFFF) > MAX_FACE ? MAX_FACE : fsize & 32'hFFF);
    w = (lay == LAYOUT_GRID) ? 3 * f : (lay == LAYOUT_PACKED) ? (5 * f) / 2 : 6 * f;
    h = (lay == LAYOUT_GRID) ? 2 * f : (lay == LAYOUT_PACKED) ? (3 * f) / 2 : f;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8)
        send_pixel(14'($urandom_range(w - 1)), 12'($urandom_range(h - 1)));
      else
        send_pixel(14'($urandom), 12'($urandom));
    end
  endtask

  initial begin
    #2_000_000;
    $display("testbench: errors");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed at reset setting: corners, centre, face seams and out-of-image saturation
    send_pixel(0, 0);
    send_pixel(3071, 511);
    send_pixel(3071, 0);
    send_pixel(0, 511);
    send_pixel(256, 256);
    send_pixel(511, 256);
    send_pixel(512, 256);
    send_pixel(1023, 255);
    send_pixel(1024, 256);
    send_pixel(1791, 100);
    send_pixel(2304, 256);
    send_pixel(2815, 400);
    send_pixel(14'h3FFF, 12'hFFF);
    send_pixel(1536, 12'hFFF);
    send_pixel(14'h3FFF, 0);

    // the sender waits until the pipeline is empty
    drain();

    // long stretch with no idle cycles
    quiet_sender = 1'b1;
    run_phase(LAYOUT_GRID, 64, 256, 90);
    quiet_sender = 1'b0;
    run_phase(LAYOUT_PACKED, 100, 300, 90);
    run_phase(LAYOUT_PACKED, 2048, 4096, 60);
    run_phase(LAYOUT_STRIP, 1, 1, 30);
    run_phase(LAYOUT_GRID, 1, 4096, 30);
    run_phase(LAYOUT_PACKED, 1, 1000, 30);
    run_phase(LAYOUT_SPARE, 37, 777, 60);
    run_phase(LAYOUT_STRIP, 0, 0, 30);
    run_phase(LAYOUT_GRID, 4095, 8191, 60);
    run_phase(LAYOUT_PACKED, 7, 13, 80);
    run_phase(LAYOUT_GRID, 2048, 1, 60);
    run_phase(LAYOUT_STRIP, 2047, 4095, 60);

    drain();
    repeat (60) @(posedge clk_i);
    $display("covered %0d pixels over %0d register settings, all layouts and size extremes",
             remap_sb.items, phase_count + 1);
    $display("%0d results checked, %0d mismatches", remap_sb.results, remap_sb.errors);
    if (remap_sb.errors == 0 && remap_sb.exp_x_q.size() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule
